// ===== hw/rtl/fpvr_pkg.sv =====
package fpvr_pkg;

    // default sizes
    localparam int ANGLE_BITS_DEF   = 16;
    localparam int ROTATE_STEPS_DEF = 16;

    // stream word layout
    localparam int IN_FIELD_W  = 16;
    localparam int MASK_W      = 7;
    localparam int S_TDATA_W   = 128;
    localparam int OUT_W       = 17;
    localparam int M_TDATA_W   = 40;

    // validity mask bits
    localparam int VM_PITCH    = 0;
    localparam int VM_ROLL     = 1;
    localparam int VM_VTRACK   = 2;
    localparam int VM_HDG_MAG  = 3;
    localparam int VM_TRK_MAG  = 4;
    localparam int VM_HDG_TRUE = 5;
    localparam int VM_TRK_TRUE = 6;

    // 1/K in Q30 and the fraction bits kept through the rotation
    localparam logic signed [30:0] GAIN_INV_Q30 = 31'sd652032874;
    localparam int FRAC_BITS = 8;
    localparam int PRESCALE_SHIFT = 30 - FRAC_BITS;

    // rotation angle is carried as a 32-bit turn
    localparam int TURN_BITS = 32;
    localparam int Z_W       = 34;

    // result saturation limits
    localparam int OUT_MAX = 65535;
    localparam int OUT_MIN = -65536;

    // arctangent of 2^-i in 32-bit turn units
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] val;
        unique case (idx)
            5'd0:  val = 32'd536870912;
            5'd1:  val = 32'd316933406;
            5'd2:  val = 32'd167458907;
            5'd3:  val = 32'd85004756;
            5'd4:  val = 32'd42667331;
            5'd5:  val = 32'd21354465;
            5'd6:  val = 32'd10679838;
            5'd7:  val = 32'd5340245;
            5'd8:  val = 32'd2670163;
            5'd9:  val = 32'd1335087;
            5'd10: val = 32'd667544;
            5'd11: val = 32'd333772;
            5'd12: val = 32'd166886;
            5'd13: val = 32'd83443;
            5'd14: val = 32'd41722;
            5'd15: val = 32'd20861;
            5'd16: val = 32'd10430;
            5'd17: val = 32'd5215;
            5'd18: val = 32'd2608;
            5'd19: val = 32'd1304;
            5'd20: val = 32'd652;
            5'd21: val = 32'd326;
            5'd22: val = 32'd163;
            5'd23: val = 32'd81;
            5'd24: val = 32'd41;
            5'd25: val = 32'd20;
            5'd26: val = 32'd10;
            5'd27: val = 32'd5;
            5'd28: val = 32'd3;
            5'd29: val = 32'd1;
            5'd30: val = 32'd1;
            5'd31: val = 32'd0;
            default: val = 32'd0;
        endcase
        return val;
    endfunction

endpackage

// ===== hw/rtl/flight_path_vector_rotate.sv =====
// Flight path marker offsets from one attitude sample.
// Input words arrive on the s_ channel (s_tvalid/s_tready/s_tdata) and hold
// pitch, roll, vertical track, both heading/track pairs, a validity mask,
// the display request and weight on wheels. Each accepted word yields exactly
// one result word on the m_ channel: alpha, beta, marker_visible and
// marker_failure.
// Sequence: a complete sample passes through ST_MUL_H, ST_MUL_V, the
// ROTATE_STEPS rotation steps (sixteen by default), ST_ROUND and ST_DONE
// before m_tvalid rises; the next word is taken once the sequencer is idle.
// A sample with missing inputs goes straight to ST_DONE after accept and
// repeats the last alpha/beta. The work is done by the single rotation
// unit (one shift-add step per cycle) and the shared multiplier used once
// for each vector component.
// s_tready is high only while the sequencer is idle, so one word is in work
// at a time. The result sits in an output register: the next word is taken
// while that result waits, and work finishing behind a stalled m_tready waits
// until the register is free.
// Reset (aresetn low, synchronous) empties the output register, returns the
// sequencer to idle and clears the held alpha/beta to zero.
module flight_path_vector_rotate #(
    parameter int ANGLE_BITS   = fpvr_pkg::ANGLE_BITS_DEF,
    parameter int ROTATE_STEPS = fpvr_pkg::ROTATE_STEPS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // pitch, roll, vertical_track, heading_magnetic, lateral_track_magnetic,
    // heading_true, lateral_track_true (16 each), valid_mask (7),
    // show_request (1), on_ground (1), zero fill
    input  logic [fpvr_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // alpha (17), beta (17), marker_visible (1), marker_failure (1), zero fill
    output logic [fpvr_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int XW     = ANGLE_BITS + 10;
    localparam int PW     = ANGLE_BITS + 31;
    localparam int CNT_W  = $clog2(ROTATE_STEPS);
    localparam int ZSHIFT = fpvr_pkg::TURN_BITS - ANGLE_BITS;
    localparam int FW     = fpvr_pkg::IN_FIELD_W;
    localparam int OW     = fpvr_pkg::OUT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_H,
        ST_MUL_V,
        ST_ROT,
        ST_ROUND,
        ST_DONE
    } state_t;

    state_t                      state_reg, state_next;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [fpvr_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic signed [OW-1:0]        held_alpha_reg, held_alpha_next;
    logic signed [OW-1:0]        held_beta_reg, held_beta_next;
    logic                        visible_reg, visible_next;
    logic                        failure_reg, failure_next;
    logic                        flip_reg, flip_next;
    logic signed [ANGLE_BITS-1:0] h_reg, h_next;
    logic signed [ANGLE_BITS-1:0] v_reg, v_next;
    logic signed [XW-1:0]        x_reg, x_next;
    logic signed [XW-1:0]        y_reg, y_next;
    logic signed [fpvr_pkg::Z_W-1:0] z_reg, z_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;

    // input field unpacking
    logic signed [FW-1:0] in_pitch, in_roll, in_vtrack;
    logic signed [FW-1:0] in_hdg_mag, in_trk_mag, in_hdg_true, in_trk_true;
    logic [fpvr_pkg::MASK_W-1:0] in_mask;
    logic in_show, in_ground;

    assign in_pitch    = s_tdata[15:0];
    assign in_roll     = s_tdata[31:16];
    assign in_vtrack   = s_tdata[47:32];
    assign in_hdg_mag  = s_tdata[63:48];
    assign in_trk_mag  = s_tdata[79:64];
    assign in_hdg_true = s_tdata[95:80];
    assign in_trk_true = s_tdata[111:96];
    assign in_mask     = s_tdata[118:112];
    assign in_show     = s_tdata[119];
    assign in_ground   = s_tdata[120];

    // source selection and wrapped differences
    logic use_mag, use_true, complete;
    logic signed [ANGLE_BITS-1:0] sel_hdg, sel_trk, vdiff, hdiff, roll_a;
    logic signed [fpvr_pkg::TURN_BITS-1:0] z_turn;
    logic signed [fpvr_pkg::Z_W-1:0] z_start;
    logic roll_flip;

    always_comb begin
        use_mag  = in_mask[fpvr_pkg::VM_HDG_MAG] & in_mask[fpvr_pkg::VM_TRK_MAG];
        use_true = in_mask[fpvr_pkg::VM_HDG_TRUE] & in_mask[fpvr_pkg::VM_TRK_TRUE];
        complete = in_mask[fpvr_pkg::VM_PITCH] & in_mask[fpvr_pkg::VM_ROLL]
                 & in_mask[fpvr_pkg::VM_VTRACK] & (use_mag | use_true);
        if (use_mag) begin
            sel_hdg = ANGLE_BITS'(in_hdg_mag);
            sel_trk = ANGLE_BITS'(in_trk_mag);
        end else begin
            sel_hdg = ANGLE_BITS'(in_hdg_true);
            sel_trk = ANGLE_BITS'(in_trk_true);
        end
        vdiff  = ANGLE_BITS'(in_pitch) - ANGLE_BITS'(in_vtrack);
        hdiff  = sel_hdg - sel_trk;
        roll_a = ANGLE_BITS'(in_roll);
        // roll as a 32-bit turn, folded into +/-90 degrees
        z_turn = fpvr_pkg::TURN_BITS'(roll_a) <<< ZSHIFT;
        if (z_turn > 32'sd1073741824) begin
            z_start   = fpvr_pkg::Z_W'(z_turn) - 34'sd2147483648;
            roll_flip = 1'b1;
        end else if (z_turn < -32'sd1073741824) begin
            z_start   = fpvr_pkg::Z_W'(z_turn) + 34'sd2147483648;
            roll_flip = 1'b1;
        end else begin
            z_start   = fpvr_pkg::Z_W'(z_turn);
            roll_flip = 1'b0;
        end
    end

    // shared prescale multiplier
    logic signed [ANGLE_BITS-1:0] mul_a;
    logic signed [PW-1:0]         prod;
    logic signed [XW-1:0]         scaled, scaled_adj;

    always_comb begin
        mul_a      = (state_reg == ST_MUL_H) ? h_reg : v_reg;
        prod       = mul_a * fpvr_pkg::GAIN_INV_Q30;
        scaled     = XW'(prod >>> fpvr_pkg::PRESCALE_SHIFT);
        scaled_adj = flip_reg ? -scaled : scaled;
    end

    // rotation step unit
    logic signed [XW-1:0] xs, ys, x_step, y_step;
    logic signed [fpvr_pkg::Z_W-1:0] atan_z, z_step;

    always_comb begin
        xs     = x_reg >>> cnt_reg;
        ys     = y_reg >>> cnt_reg;
        atan_z = fpvr_pkg::Z_W'(fpvr_pkg::atan_turn(5'(cnt_reg)));
        if (!z_reg[fpvr_pkg::Z_W-1]) begin
            x_step = x_reg - ys;
            y_step = y_reg + xs;
            z_step = z_reg - atan_z;
        end else begin
            x_step = x_reg + ys;
            y_step = y_reg - xs;
            z_step = z_reg + atan_z;
        end
    end

    // round to whole units and saturate
    logic signed [XW-1:0] x_rnd, y_rnd;
    logic signed [OW-1:0] alpha_sat, beta_sat;

    always_comb begin
        x_rnd = (x_reg + XW'(128)) >>> fpvr_pkg::FRAC_BITS;
        y_rnd = (y_reg + XW'(128)) >>> fpvr_pkg::FRAC_BITS;
        if (y_rnd > XW'(fpvr_pkg::OUT_MAX)) begin
            alpha_sat = OW'(fpvr_pkg::OUT_MAX);
        end else if (y_rnd < XW'(fpvr_pkg::OUT_MIN)) begin
            alpha_sat = OW'(fpvr_pkg::OUT_MIN);
        end else begin
            alpha_sat = OW'(y_rnd);
        end
        if (x_rnd > XW'(fpvr_pkg::OUT_MAX)) begin
            beta_sat = OW'(fpvr_pkg::OUT_MAX);
        end else if (x_rnd < XW'(fpvr_pkg::OUT_MIN)) begin
            beta_sat = OW'(fpvr_pkg::OUT_MIN);
        end else begin
            beta_sat = OW'(x_rnd);
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // sequencer
    always_comb begin
        state_next      = state_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        held_alpha_next = held_alpha_reg;
        held_beta_next  = held_beta_reg;
        visible_next    = visible_reg;
        failure_next    = failure_reg;
        flip_next       = flip_reg;
        h_next          = h_reg;
        v_next          = v_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        z_next          = z_reg;
        cnt_next        = cnt_reg;

        // output word taken
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    h_next    = hdiff;
                    v_next    = vdiff;
                    z_next    = z_start;
                    flip_next = roll_flip;
                    cnt_next  = '0;
                    if (complete) begin
                        visible_next = in_show & ~in_ground;
                        failure_next = 1'b0;
                        state_next   = ST_MUL_H;
                    end else begin
                        visible_next = 1'b0;
                        failure_next = in_show;
                        state_next   = ST_DONE;
                    end
                end
            end
            ST_MUL_H: begin
                x_next     = scaled_adj;
                state_next = ST_MUL_V;
            end
            ST_MUL_V: begin
                y_next     = scaled_adj;
                state_next = ST_ROT;
            end
            ST_ROT: begin
                x_next = x_step;
                y_next = y_step;
                z_next = z_step;
                if (cnt_reg == CNT_W'(ROTATE_STEPS - 1)) begin
                    state_next = ST_ROUND;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_ROUND: begin
                held_alpha_next = alpha_sat;
                held_beta_next  = beta_sat;
                state_next      = ST_DONE;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'b0000, failure_reg, visible_reg,
                                     held_beta_reg, held_alpha_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_tvalid_reg   <= 1'b0;
            held_alpha_reg <= '0;
            held_beta_reg  <= '0;
            cnt_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            m_tvalid_reg   <= m_tvalid_next;
            held_alpha_reg <= held_alpha_next;
            held_beta_reg  <= held_beta_next;
            cnt_reg        <= cnt_next;
        end
        m_tdata_reg <= m_tdata_next;
        visible_reg <= visible_next;
        failure_reg <= failure_next;
        flip_reg    <= flip_next;
        h_reg       <= h_next;
        v_reg       <= v_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        z_reg       <= z_next;
    end

    // one word in work at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input word taken while a word is in work");

    // step counter only runs during the rotation and is clear in the multiply states
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg != '0) |-> (state_reg == ST_ROT || state_reg == ST_ROUND
                             || state_reg == ST_DONE || state_reg == ST_IDLE))
        else $error("step counter active outside rotation");

    // a marker is never both shown and failed
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[34] && m_tdata[35]))
        else $error("marker visible and failed at once");

    // a pending result is not overwritten
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && m_tvalid && !m_tready) |=> state_reg == ST_DONE)
        else $error("result loaded over a stalled word");

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // one attitude sample as it goes into the block
    typedef struct packed {
        logic signed [15:0] pitch;
        logic signed [15:0] roll;
        logic signed [15:0] vtrack;
        logic signed [15:0] hdg_mag;
        logic signed [15:0] trk_mag;
        logic signed [15:0] hdg_true;
        logic signed [15:0] trk_true;
        logic [fpvr_pkg::MASK_W-1:0] mask;
        logic               show;
        logic               ground;
    } sample_t;

    // one marker result word
    typedef struct packed {
        logic signed [fpvr_pkg::OUT_W-1:0] alpha;
        logic signed [fpvr_pkg::OUT_W-1:0] beta;
        logic                    visible;
        logic                    failure;
    } marker_t;

    typedef struct packed {
        sample_t smp;
        logic    known;
        marker_t want;
    } stim_row_t;

    // validity mask groups
    localparam logic [fpvr_pkg::MASK_W-1:0] M_ATT = (7'd1 << fpvr_pkg::VM_PITCH)
        | (7'd1 << fpvr_pkg::VM_ROLL) | (7'd1 << fpvr_pkg::VM_VTRACK);
    localparam logic [fpvr_pkg::MASK_W-1:0] M_MAG = (7'd1 << fpvr_pkg::VM_HDG_MAG)
        | (7'd1 << fpvr_pkg::VM_TRK_MAG);
    localparam logic [fpvr_pkg::MASK_W-1:0] M_TRUE = (7'd1 << fpvr_pkg::VM_HDG_TRUE)
        | (7'd1 << fpvr_pkg::VM_TRK_TRUE);
    localparam logic [fpvr_pkg::MASK_W-1:0] M_ALL = M_ATT | M_MAG | M_TRUE;

    localparam longint INV_GAIN    = 64'sd652032874;
    localparam longint QUARTER_TRN = 64'sd1 << 30;
    localparam longint HALF_TRN    = 64'sd1 << 31;
    localparam int     N_STEPS     = 16;
    localparam int     PHASE_WORDS = 150;
    localparam int     CYCLE_LIMIT = 200000;
    localparam int     DRAIN_LIMIT = 20000;

    logic                           aclk;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [fpvr_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [fpvr_pkg::M_TDATA_W-1:0] m_tdata;

    // arctangent of 2^-i in 32-bit turn units
    longint atan_step [0:N_STEPS-1] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861
    };

    longint    held_alpha_q = 0;
    longint    held_beta_q  = 0;
    marker_t   pending_markers [$];
    stim_row_t directed_rows [$];
    int        words_sent     = 0;
    int        mismatch_count = 0;
    int        send_gap_pct   = 8;
    int        rx_stall_pct   = 70;
    int        cycle_count    = 0;
    logic      rx_hold        = 1'b0;

    flight_path_vector_rotate dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // binary angle difference folded back to the signed 16-bit circle
    function automatic longint wrap_bam(input longint v);
        logic [15:0] m;
        m = v[15:0];
        return longint'($signed(m));
    endfunction

    function automatic longint clamp17(input longint v);
        if (v > fpvr_pkg::OUT_MAX) return fpvr_pkg::OUT_MAX;
        if (v < fpvr_pkg::OUT_MIN) return fpvr_pkg::OUT_MIN;
        return v;
    endfunction

    // expected marker word for one sample; updates the held offsets
    function automatic marker_t predict_marker(input sample_t smp);
        marker_t res;
        longint  hdg, trk, vdiff, hdiff, z, x, y, xs, ys;
        logic    have_pair;
        have_pair = 1'b0;
        hdg = 0;
        trk = 0;
        if ((smp.mask & M_MAG) == M_MAG) begin
            hdg = longint'(smp.hdg_mag);
            trk = longint'(smp.trk_mag);
            have_pair = 1'b1;
        end else if ((smp.mask & M_TRUE) == M_TRUE) begin
            hdg = longint'(smp.hdg_true);
            trk = longint'(smp.trk_true);
            have_pair = 1'b1;
        end
        if ((smp.mask & M_ATT) == M_ATT && have_pair) begin
            vdiff = wrap_bam(longint'(smp.pitch) - longint'(smp.vtrack));
            hdiff = wrap_bam(hdg - trk);
            z = longint'(smp.roll) * 65536;
            x = (hdiff * INV_GAIN) >>> (30 - fpvr_pkg::FRAC_BITS);
            y = (vdiff * INV_GAIN) >>> (30 - fpvr_pkg::FRAC_BITS);
            // fold roll into +/-90 degrees
            if (z > QUARTER_TRN) begin
                z = z - HALF_TRN;
                x = -x;
                y = -y;
            end else if (z < -QUARTER_TRN) begin
                z = z + HALF_TRN;
                x = -x;
                y = -y;
            end
            for (int i = 0; i < N_STEPS; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0) begin
                    x = x - ys;
                    y = y + xs;
                    z = z - atan_step[i];
                end else begin
                    x = x + ys;
                    y = y - xs;
                    z = z + atan_step[i];
                end
            end
            held_beta_q  = clamp17((x + 128) >>> fpvr_pkg::FRAC_BITS);
            held_alpha_q = clamp17((y + 128) >>> fpvr_pkg::FRAC_BITS);
            res.visible = smp.show;
            res.failure = 1'b0;
        end else begin
            res.visible = 1'b0;
            res.failure = smp.show;
        end
        if (smp.ground) res.visible = 1'b0;
        res.alpha = held_alpha_q[fpvr_pkg::OUT_W-1:0];
        res.beta  = held_beta_q[fpvr_pkg::OUT_W-1:0];
        return res;
    endfunction

    function automatic logic [fpvr_pkg::S_TDATA_W-1:0] pack_sample(input sample_t smp);
        logic [fpvr_pkg::S_TDATA_W-1:0] w;
        w = '0;
        w[120:0] = {smp.ground, smp.show, smp.mask, smp.trk_true, smp.hdg_true,
                    smp.trk_mag, smp.hdg_mag, smp.vtrack, smp.roll, smp.pitch};
        return w;
    endfunction

    function automatic sample_t mk(input logic signed [15:0] p, r, vt, hm, tm, ht, tt,
                                   input logic [fpvr_pkg::MASK_W-1:0] mask,
                                   input logic show, ground);
        sample_t smp;
        smp.pitch    = p;
        smp.roll     = r;
        smp.vtrack   = vt;
        smp.hdg_mag  = hm;
        smp.trk_mag  = tm;
        smp.hdg_true = ht;
        smp.trk_true = tt;
        smp.mask     = mask;
        smp.show     = show;
        smp.ground   = ground;
        return smp;
    endfunction

    function automatic marker_t mrk(input int a, b, input logic vis, fail);
        marker_t m;
        m.alpha   = fpvr_pkg::OUT_W'(a);
        m.beta    = fpvr_pkg::OUT_W'(b);
        m.visible = vis;
        m.failure = fail;
        return m;
    endfunction

    // angles biased toward the circle's edges and quarter points
    function automatic logic signed [15:0] pick_angle();
        case ($urandom_range(0, 11))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh4000;
            3: return 16'shC000;
            4: return 16'sh4001;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic sample_t random_sample();
        sample_t smp;
        smp = mk(pick_angle(), pick_angle(), pick_angle(), pick_angle(), pick_angle(),
                 pick_angle(), pick_angle(), M_ALL, 1'($urandom_range(0, 1)),
                 $urandom_range(0, 3) == 0);
        case ($urandom_range(0, 9))
            0, 1: smp.mask = 7'($urandom_range(0, 127));
            2:    smp.mask = M_ATT | M_MAG;
            3:    smp.mask = M_ATT | M_TRUE;
            4:    smp.mask = M_ALL ^ (7'd1 << $urandom_range(0, fpvr_pkg::MASK_W - 1));
            default: smp.mask = M_ALL;
        endcase
        return smp;
    endfunction

    task automatic log_mismatch(input string msg);
        if (mismatch_count < 10) $display("mismatch: %s", msg);
        mismatch_count++;
    endtask

    // offer one word, wait for the handshake, queue its expected result
    task automatic send_sample(input sample_t smp, input logic known, input marker_t want);
        marker_t pred;
        while ($urandom_range(0, 99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pack_sample(smp);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pred = predict_marker(smp);
        pending_markers.push_back(known ? want : pred);
        words_sent++;
        @(negedge aclk);
    endtask

    // receiver readiness, with an optional long hold
    always @(negedge aclk) begin
        if (!aresetn || rx_hold) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // one long receiver stall while the sender keeps offering words
    initial begin
        wait (words_sent >= 24 + 2 * PHASE_WORDS + 20);
        @(posedge aclk);
        rx_hold = 1'b1;
        repeat (300) @(posedge aclk);
        rx_hold = 1'b0;
    end

    // result checker
    always @(posedge aclk) begin
        marker_t got;
        marker_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.alpha   = m_tdata[16:0];
            got.beta    = m_tdata[33:17];
            got.visible = m_tdata[34];
            got.failure = m_tdata[35];
            if (pending_markers.size() == 0) begin
                log_mismatch($sformatf("unexpected word alpha=%0d beta=%0d vis=%0b fail=%0b",
                                       got.alpha, got.beta, got.visible, got.failure));
            end else begin
                want = pending_markers.pop_front();
                if (got.alpha !== want.alpha || got.beta !== want.beta ||
                    got.visible !== want.visible || got.failure !== want.failure) begin
                    log_mismatch($sformatf(
                        "exp alpha=%0d beta=%0d vis=%0b fail=%0b, got %0d %0d %0b %0b",
                        want.alpha, want.beta, want.visible, want.failure,
                        got.alpha, got.beta, got.visible, got.failure));
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL flight_path_vector_rotate");
            $finish;
        end
    end

    initial begin
        int drain;
        // missing inputs right after reset give the cleared offsets
        directed_rows.push_back('{mk(16'sh1234, 16'sh0567, 16'sh0890, 16'sh0ABC, 16'sh0DEF,
            16'sh1111, 16'sh2222, '0, 1'b1, 1'b0), 1'b1, mrk(0, 0, 1'b0, 1'b1)});
        directed_rows.push_back('{mk('0, '0, '0, '0, '0, '0, '0, '0, 1'b0, 1'b0),
            1'b1, mrk(0, 0, 1'b0, 1'b0)});
        // zero vector stays zero
        directed_rows.push_back('{mk('0, '0, '0, '0, '0, '0, '0, M_ALL, 1'b1, 1'b0),
            1'b1, mrk(0, 0, 1'b1, 1'b0)});
        directed_rows.push_back('{mk('0, '0, '0, '0, '0, '0, '0, M_ALL, 1'b1, 1'b1),
            1'b1, mrk(0, 0, 1'b0, 1'b0)});
        // valid sample, then each attitude input dropped in turn
        directed_rows.push_back('{mk(16'sd16384, '0, '0, '0, '0, '0, '0, M_ATT | M_MAG,
            1'b1, 1'b0), 1'b0, '0});
        directed_rows.push_back('{mk(16'sd100, 16'sd200, 16'sd300, 16'sd400, 16'sd500,
            16'sd600, 16'sd700, M_ALL ^ (7'd1 << fpvr_pkg::VM_PITCH), 1'b1, 1'b0),
            1'b0, '0});
        directed_rows.push_back('{mk(16'sd100, 16'sd200, 16'sd300, 16'sd400, 16'sd500,
            16'sd600, 16'sd700, M_ALL ^ (7'd1 << fpvr_pkg::VM_ROLL), 1'b0, 1'b0),
            1'b0, '0});
        directed_rows.push_back('{mk(16'sd100, 16'sd200, 16'sd300, 16'sd400, 16'sd500,
            16'sd600, 16'sd700, M_ALL ^ (7'd1 << fpvr_pkg::VM_VTRACK), 1'b1, 1'b1),
            1'b0, '0});
        // magnetic pair broken, true pair taken
        directed_rows.push_back('{mk(16'sd3000, 16'sd1000, -16'sd2000, 16'sd9000,
            -16'sd9000, 16'sd1200, 16'sd300, M_ALL ^ (7'd1 << fpvr_pkg::VM_HDG_MAG),
            1'b1, 1'b0), 1'b0, '0});
        directed_rows.push_back('{mk(16'sd3000, -16'sd1000, -16'sd2000, 16'sd9000,
            -16'sd9000, -16'sd1200, 16'sd300, M_ALL ^ (7'd1 << fpvr_pkg::VM_TRK_MAG),
            1'b1, 1'b0), 1'b0, '0});
        // both pairs broken
        directed_rows.push_back('{mk(16'sd3000, 16'sd1000, -16'sd2000, 16'sd9000,
            -16'sd9000, 16'sd1200, 16'sd300,
            M_ATT | (7'd1 << fpvr_pkg::VM_HDG_MAG) | (7'd1 << fpvr_pkg::VM_HDG_TRUE),
            1'b1, 1'b0), 1'b0, '0});
        // magnetic pair only
        directed_rows.push_back('{mk(-16'sd500, 16'sd4000, 16'sd700, 16'sd1500, -16'sd2500,
            16'sh7FFF, 16'sh8000, M_ATT | M_MAG, 1'b1, 1'b0), 1'b0, '0});
        // vertical difference wraps at the circle's edges
        directed_rows.push_back('{mk(16'sh8000, '0, 16'sh7FFF, '0, '0, '0, '0, M_ALL,
            1'b1, 1'b0), 1'b0, '0});
        directed_rows.push_back('{mk(16'sh7FFF, '0, 16'sh8000, '0, '0, '0, '0, M_ALL,
            1'b1, 1'b0), 1'b0, '0});
        // heading difference of exactly 180 degrees
        directed_rows.push_back('{mk('0, '0, '0, '0, 16'sh8000, '0, '0, M_ALL, 1'b1, 1'b0),
            1'b0, '0});
        // roll at and around the quarter turns and the half turn
        directed_rows.push_back('{mk(16'sd5000, 16'sh7FFF, '0, 16'sd8000, '0, '0, '0, M_ALL,
            1'b1, 1'b0), 1'b0, '0});
        directed_rows.push_back('{mk(16'sd5000, 16'sh8000, '0, 16'sd8000, '0, '0, '0, M_ALL,
            1'b1, 1'b0), 1'b0, '0});
        directed_rows.push_back('{mk(16'sd5000, 16'sd16384, '0, 16'sd8000, '0, '0, '0, M_ALL,
            1'b1, 1'b0), 1'b0, '0});
        directed_rows.push_back('{mk(16'sd5000, 16'sd16385, '0, 16'sd8000, '0, '0, '0, M_ALL,
            1'b1, 1'b0), 1'b0, '0});
        directed_rows.push_back('{mk(16'sd5000, -16'sd16384, '0, 16'sd8000, '0, '0, '0,
            M_ALL, 1'b1, 1'b0), 1'b0, '0});
        directed_rows.push_back('{mk(16'sd5000, -16'sd16385, '0, 16'sd8000, '0, '0, '0,
            M_ALL, 1'b1, 1'b0), 1'b0, '0});
        // largest vector at 45 degrees of roll
        directed_rows.push_back('{mk(16'sh8000, 16'sd8192, '0, 16'sh8000, '0, '0, '0, M_ALL,
            1'b1, 1'b0), 1'b0, '0});
        directed_rows.push_back('{mk(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
            16'sh8000, 16'sh7FFF, M_ALL, 1'b0, 1'b0), 1'b0, '0});
        directed_rows.push_back('{mk(-16'sd7000, -16'sd3000, 16'sd2500, -16'sd12000,
            16'sd6000, '0, '0, M_ALL, 1'b1, 1'b1), 1'b0, '0});

        // reset
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[k])
            send_sample(directed_rows[k].smp, directed_rows[k].known, directed_rows[k].want);

        // random words in three idling phases
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_gap_pct = 8;
                    rx_stall_pct = 70;
                end
                1: begin
                    send_gap_pct = 70;
                    rx_stall_pct = 8;
                end
                default: begin
                    send_gap_pct = 0;
                    rx_stall_pct = 0;
                end
            endcase
            repeat (PHASE_WORDS) send_sample(random_sample(), 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        // drain
        drain = 0;
        while (pending_markers.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge aclk);
            drain++;
        end
        repeat (40) @(posedge aclk);
        if (pending_markers.size() != 0)
            log_mismatch($sformatf("%0d result words never arrived", pending_markers.size()));

        if (mismatch_count == 0) begin
            $display("PASS flight_path_vector_rotate");
        end else begin
            $display("FAIL flight_path_vector_rotate");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/fpvr_pkg.sv
hw/rtl/flight_path_vector_rotate.sv
tb/sv/testbench.sv
